// ===== design/mefa_pkg.sv =====
// ----------------------------------------------------------------------------
// mefa_pkg: shared types and constants of the force accumulator
// Field widths, configuration register indexes, step codes, flag bits and
// accumulator limits used by the channel interfaces and the datapath.
// ----------------------------------------------------------------------------
package mefa_pkg;

    // Field widths
    localparam int CELL_W     = 10;
    localparam int STEP_W     = 2;
    localparam int POP_W      = 32;
    localparam int CRD_W      = 18;
    localparam int SIZE_W     = 11;
    localparam int FLAG_W     = 4;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    typedef logic        [CELL_W-1:0] t_cell;
    typedef logic signed [STEP_W-1:0] t_step;
    typedef logic        [POP_W-1:0]  t_pop;
    typedef logic        [CRD_W-1:0]  t_coord;
    typedef logic        [SIZE_W-1:0] t_size;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_CENTER_Z,
        CFG_RADIUS,
        CFG_SIZE_X,
        CFG_SIZE_Y,
        CFG_SIZE_Z,
        CFG_FLAGS
    } t_cfg_reg;

    localparam t_size SIZE_RESET = SIZE_W'(64);

    // Flag bit positions
    localparam int FLAG_PER_X     = 0;
    localparam int FLAG_ONE_SIDED = 3;

    // Step codes
    localparam t_step STEP_ZERO = 2'b00;
    localparam t_step STEP_POS  = 2'b01;
    localparam t_step STEP_BAD  = 2'b10;
    localparam t_step STEP_NEG  = 2'b11;

    // Accumulator limits
    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

// ===== design/mefa_link_if.sv =====
// ----------------------------------------------------------------------------
// mefa_link_if: lattice link channel
// Valid/ready channel that carries one lattice link per beat.
// ----------------------------------------------------------------------------
interface mefa_link_if;
    import mefa_pkg::*;

    logic  valid;
    logic  ready;
    t_cell cell_x;
    t_cell cell_y;
    t_cell cell_z;
    t_step step_x;
    t_step step_y;
    t_step step_z;
    t_pop  pop_out;
    t_pop  pop_in;
    logic  last;

    modport source (
        output valid, cell_x, cell_y, cell_z, step_x, step_y, step_z,
               pop_out, pop_in, last,
        input  ready
    );

    modport sink (
        input  valid, cell_x, cell_y, cell_z, step_x, step_y, step_z,
               pop_out, pop_in, last,
        output ready
    );
endinterface

// ===== design/mefa_force_if.sv =====
// ----------------------------------------------------------------------------
// mefa_force_if: force result channel
// Valid/ready channel that carries one force vector per beat.
// ----------------------------------------------------------------------------
interface mefa_force_if;
    import mefa_pkg::*;

    logic valid;
    logic ready;
    t_acc force_x;
    t_acc force_y;
    t_acc force_z;

    modport source (
        output valid, force_x, force_y, force_z,
        input  ready
    );

    modport sink (
        input  valid, force_x, force_y, force_z,
        output ready
    );
endinterface

// ===== design/momentum_exchange_force_accumulator.sv =====
// ----------------------------------------------------------------------------
// momentum_exchange_force_accumulator: sphere force by momentum exchange
// Tests each lattice link against a sphere, accumulates the momentum of
// boundary links in three saturating sums and emits the negated sums on
// the last link of a sweep.
//
//   Channel   Dir  Beat                                Handshake
//   i_link    in   one lattice link                    valid / ready
//   o_force   out  force on the sphere, per last link  valid / ready
//   i_cfg_*   in   one register write                  write enable only
//
// One link is accepted per cycle unless the chain stalls. A last link passes the
// input register, neighbor and offset stage, square stage, distance compare
// stage, then the accumulator and output register, before its result appears.
// Reset is synchronous: it clears the stage valids, the sums, the output
// valid and loads the register defaults.
// An untaken result holds only a last link at the compare stage, and the links
// behind it; the links ahead of it keep flowing into the sums.
// ----------------------------------------------------------------------------
module momentum_exchange_force_accumulator #(
    parameter int MAX_AXIS_CELLS = 1024,
    parameter int POP_BITS       = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mefa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mefa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mefa_link_if.sink                         i_link,
    mefa_force_if.source                      o_force
);
    import mefa_pkg::*;

    // Datapath widths
    localparam int SW   = $clog2(MAX_AXIS_CELLS + 1);
    localparam int AW   = ((SW > CELL_W) ? SW : CELL_W) + 1;
    localparam int DW   = AW + 9;
    localparam int SQW  = 2 * DW;
    localparam int DSW  = SQW + 2;
    localparam int R2W  = 2 * CRD_W;
    localparam int CMPW = ((DSW > R2W) ? DSW : R2W);
    localparam int DMW  = POP_W + 1;
    localparam logic [POP_W-1:0] POP_MASK = (POP_BITS >= POP_W) ? {POP_W{1'b1}}
                                          : POP_W'((64'd1 << POP_BITS) - 64'd1);

    typedef struct packed {
        logic nz;
        logic neg;
        logic bad;
    } t_step_dec;

    typedef struct packed {
        logic                 ok;
        logic signed [AW-1:0] idx;
    } t_nbr;

    // Effective axis size: zero acts as one, clamp to the axis limit
    function automatic logic signed [AW-1:0] eff_size(input t_size s);
        logic signed [AW-1:0] v;
        v = $signed(AW'(s));
        if (s == '0) begin
            v = AW'(1);
        end else if (v > AW'(MAX_AXIS_CELLS)) begin
            v = AW'(MAX_AXIS_CELLS);
        end
        return v;
    endfunction

    function automatic t_step_dec step_decode(input t_step s);
        t_step_dec d;
        d = '0;
        case (s)
            STEP_ZERO: begin
                d.nz = 1'b0;
            end
            STEP_POS: begin
                d.nz = 1'b1;
            end
            STEP_NEG: begin
                d.nz  = 1'b1;
                d.neg = 1'b1;
            end
            STEP_BAD: begin
                d.bad = 1'b1;
            end
            default: begin
                d.bad = 1'b1;
            end
        endcase
        return d;
    endfunction

    // Neighbor index along one axis, wrapped or checked against the domain
    function automatic t_nbr neighbour(input t_cell c, input t_step_dec d,
                                       input logic signed [AW-1:0] n,
                                       input logic per);
        t_nbr                 r;
        logic signed [AW-1:0] sv;
        logic signed [AW-1:0] v;
        sv = d.nz ? (d.neg ? {AW{1'b1}} : AW'(1)) : '0;
        v  = $signed(AW'(c)) + sv;
        r.ok = 1'b1;
        if (per) begin
            if (v < 0) begin
                v = v + n;
            end else if (v >= n) begin
                v = v - n;
            end
        end else begin
            r.ok = (v >= 0) && (v < n);
        end
        r.idx = v;
        return r;
    endfunction

    // Offset of a cell center from the sphere center, signed Q12.8
    function automatic logic signed [DW-1:0] pos_delta(input logic signed [AW-1:0] i,
                                                       input t_coord ctr);
        logic signed [DW-1:0] ip;
        logic signed [DW-1:0] cp;
        ip = DW'(i);
        cp = $signed(DW'(ctr));
        return (ip <<< 8) + DW'(128) - cp;
    endfunction

    // Configuration registers
    t_coord              r_center [3];
    t_coord              r_radius;
    t_size               r_size [3];
    logic [FLAG_W-1:0]   r_flags;
    logic [R2W-1:0]      r_r2;

    // Stage 1: input register
    logic                r1_valid;
    t_cell               r1_cell [3];
    t_step               r1_step [3];
    t_pop                r1_pop_out;
    t_pop                r1_pop_in;
    logic                r1_last;

    // Stage 2: offsets and link checks
    logic                r2_valid;
    logic                r2_last;
    logic                r2_ok;
    t_step_dec           r2_dec [3];
    logic [DMW-1:0]      r2_dm;
    logic signed [DW-1:0] r2_dc [3];
    logic signed [DW-1:0] r2_dn [3];

    // Stage 3: squares
    logic                r3_valid;
    logic                r3_last;
    logic                r3_ok;
    t_step_dec           r3_dec [3];
    logic [DMW-1:0]      r3_dm;
    logic [SQW-1:0]      r3_sqc [3];
    logic [SQW-1:0]      r3_sqn [3];

    // Stage 4: sphere test result
    logic                r4_valid;
    logic                r4_last;
    logic                r4_ok;
    t_step_dec           r4_dec [3];
    logic [DMW-1:0]      r4_dm;

    // Accumulators and output register
    t_acc                r_sum [3];
    t_acc                r_force [3];
    logic                r_out_valid;

    logic                en1, en2, en3, en4;
    logic                s4_move;

    t_step_dec           n2_dec [3];
    t_nbr                n2_nbr [3];
    logic signed [AW-1:0] n2_size [3];
    logic                n2_ok;
    logic [DMW-1:0]      n2_dm;
    logic signed [DW-1:0] n2_dc [3];
    logic signed [DW-1:0] n2_dn [3];
    logic [POP_W-1:0]    n2_po;
    logic [POP_W-1:0]    n2_pi;

    logic signed [SQW-1:0] n3_sqc [3];
    logic signed [SQW-1:0] n3_sqn [3];

    logic [DSW-1:0]      n4_dc;
    logic [DSW-1:0]      n4_dn;
    logic                n4_ok;

    logic signed [ACC_W:0] n5_add [3];
    t_acc                n5_sum [3];
    t_acc                n5_neg [3];

    // Stall chain: a last link waits on an untaken result, and the links behind it wait on it
    always_comb begin
        en4     = !r4_valid || !r4_last || !r_out_valid || o_force.ready;
        en3     = !r3_valid || en4;
        en2     = !r2_valid || en3;
        en1     = !r1_valid || en2;
        s4_move = r4_valid && en4;
    end

    assign i_link.ready = en1;

    // Stage 2 logic: domain, step and neighbor checks, center offsets, momentum term
    always_comb begin
        n2_ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
            n2_dec[a]  = step_decode(r1_step[a]);
            n2_size[a] = eff_size(r_size[a]);
            n2_nbr[a]  = neighbour(r1_cell[a], n2_dec[a], n2_size[a],
                                   r_flags[FLAG_PER_X + a]);
            n2_dc[a]   = pos_delta($signed(AW'(r1_cell[a])), r_center[a]);
            n2_dn[a]   = pos_delta(n2_nbr[a].idx, r_center[a]);
            if (!($signed(AW'(r1_cell[a])) < n2_size[a]) || n2_dec[a].bad
                    || !n2_nbr[a].ok) begin
                n2_ok = 1'b0;
            end
        end
        if (!n2_dec[0].nz && !n2_dec[1].nz && !n2_dec[2].nz) begin
            n2_ok = 1'b0;
        end
        n2_po = r1_pop_out & POP_MASK;
        n2_pi = r1_pop_in & POP_MASK;
        if (r_flags[FLAG_ONE_SIDED]) begin
            n2_dm = {n2_po, 1'b0};
        end else begin
            n2_dm = DMW'(n2_po) + DMW'(n2_pi);
        end
    end

    // Stage 3 logic: squared offsets
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n3_sqc[a] = r2_dc[a] * r2_dc[a];
            n3_sqn[a] = r2_dn[a] * r2_dn[a];
        end
    end

    // Stage 4 logic: cell outside the sphere, neighbor inside or on it
    always_comb begin
        n4_dc = DSW'(r3_sqc[0]) + DSW'(r3_sqc[1]) + DSW'(r3_sqc[2]);
        n4_dn = DSW'(r3_sqn[0]) + DSW'(r3_sqn[1]) + DSW'(r3_sqn[2]);
        n4_ok = r3_ok && (CMPW'(n4_dc) > CMPW'(r_r2)) && (CMPW'(n4_dn) <= CMPW'(r_r2));
    end

    // Accumulate with saturation, negate for the output
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n5_add[a] = {r_sum[a][ACC_W-1], r_sum[a]};
            if (r4_ok && r4_dec[a].nz) begin
                if (r4_dec[a].neg) begin
                    n5_add[a] = n5_add[a] - $signed((ACC_W+1)'(r4_dm));
                end else begin
                    n5_add[a] = n5_add[a] + $signed((ACC_W+1)'(r4_dm));
                end
            end
            if (n5_add[a][ACC_W] != n5_add[a][ACC_W-1]) begin
                n5_sum[a] = n5_add[a][ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
                n5_sum[a] = n5_add[a][ACC_W-1:0];
            end
            n5_neg[a] = (n5_sum[a] == ACC_MIN) ? ACC_MAX : -n5_sum[a];
        end
    end

    // Hold configuration, derive radius squared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_center[a] <= '0;
                r_size[a]   <= SIZE_RESET;
            end
            r_radius <= '0;
            r_flags  <= '0;
            r_r2     <= '0;
        end else begin
            r_r2 <= R2W'(r_radius) * R2W'(r_radius);
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_CENTER_X: r_center[0] <= i_cfg_data[CRD_W-1:0];
                    CFG_CENTER_Y: r_center[1] <= i_cfg_data[CRD_W-1:0];
                    CFG_CENTER_Z: r_center[2] <= i_cfg_data[CRD_W-1:0];
                    CFG_RADIUS:   r_radius    <= i_cfg_data[CRD_W-1:0];
                    CFG_SIZE_X:   r_size[0]   <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Y:   r_size[1]   <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Z:   r_size[2]   <= i_cfg_data[SIZE_W-1:0];
                    CFG_FLAGS:    r_flags     <= i_cfg_data[FLAG_W-1:0];
                    default: begin
                        r_flags <= r_flags;
                    end
                endcase
            end
        end
    end

    // Advance stage valids, sums and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            if (en1) r1_valid <= i_link.valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
            if (s4_move) begin
                for (int a = 0; a < 3; a++) begin
                    r_sum[a] <= r4_last ? '0 : n5_sum[a];
                end
            end
            if (s4_move && r4_last) begin
                r_out_valid <= 1'b1;
            end else if (o_force.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_cell[0] <= i_link.cell_x;
            r1_cell[1] <= i_link.cell_y;
            r1_cell[2] <= i_link.cell_z;
            r1_step[0] <= i_link.step_x;
            r1_step[1] <= i_link.step_y;
            r1_step[2] <= i_link.step_z;
            r1_pop_out <= i_link.pop_out;
            r1_pop_in  <= i_link.pop_in;
            r1_last    <= i_link.last;
        end
        if (en2) begin
            r2_last <= r1_last;
            r2_ok   <= n2_ok;
            r2_dm   <= n2_dm;
            for (int a = 0; a < 3; a++) begin
                r2_dec[a] <= n2_dec[a];
                r2_dc[a]  <= n2_dc[a];
                r2_dn[a]  <= n2_dn[a];
            end
        end
        if (en3) begin
            r3_last <= r2_last;
            r3_ok   <= r2_ok;
            r3_dm   <= r2_dm;
            for (int a = 0; a < 3; a++) begin
                r3_dec[a] <= r2_dec[a];
                r3_sqc[a] <= $unsigned(n3_sqc[a]);
                r3_sqn[a] <= $unsigned(n3_sqn[a]);
            end
        end
        if (en4) begin
            r4_last <= r3_last;
            r4_ok   <= n4_ok;
            r4_dm   <= r3_dm;
            for (int a = 0; a < 3; a++) begin
                r4_dec[a] <= r3_dec[a];
            end
        end
        if (s4_move && r4_last) begin
            for (int a = 0; a < 3; a++) begin
                r_force[a] <= n5_neg[a];
            end
        end
    end

    // Drive the result channel
    assign o_force.valid   = r_out_valid;
    assign o_force.force_x = r_force[0];
    assign o_force.force_y = r_force[1];
    assign o_force.force_z = r_force[2];

    // A last link blocked by an untaken result stays at the compare stage
    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && r4_last && r_out_valid && !o_force.ready)
            |=> (r4_valid && r4_last))
        else $error("blocked last link left the compare stage");

    // Emitting a result clears all three sums
    a_sums_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s4_move && r4_last)
            |=> (r_sum[0] == '0 && r_sum[1] == '0 && r_sum[2] == '0))
        else $error("sums not cleared after a result");

    // A new result only follows a last link at the compare stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r4_valid && r4_last))
        else $error("result raised without a last link");

endmodule
